### design/jst_pkg.sv
// Shared types and constants for the JSON stream tokenizer.
`default_nettype none
package jst_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [3:0] EV_OBJ_BEGIN = 4'd0;
  localparam logic [3:0] EV_OBJ_END   = 4'd1;
  localparam logic [3:0] EV_ARR_BEGIN = 4'd2;
  localparam logic [3:0] EV_ARR_END   = 4'd3;
  localparam logic [3:0] EV_STR_BYTE  = 4'd4;
  localparam logic [3:0] EV_STR_END   = 4'd5;
  localparam logic [3:0] EV_TRUE      = 4'd6;
  localparam logic [3:0] EV_INTEGER   = 4'd9;
  localparam logic [3:0] EV_DONE      = 4'd10;
  localparam logic [3:0] EV_ERROR     = 4'd11;

  localparam logic [3:0] ERR_TRAILING   = 4'd0;
  localparam logic [3:0] ERR_TOO_DEEP   = 4'd1;
  localparam logic [3:0] ERR_VALUE      = 4'd2;
  localparam logic [3:0] ERR_KEY        = 4'd3;
  localparam logic [3:0] ERR_COLON      = 4'd4;
  localparam logic [3:0] ERR_OBJ_SEP    = 4'd5;
  localparam logic [3:0] ERR_ARR_SEP    = 4'd6;
  localparam logic [3:0] ERR_UNTERM     = 4'd7;
  localparam logic [3:0] ERR_CONTROL    = 4'd8;
  localparam logic [3:0] ERR_U_ESCAPE   = 4'd9;
  localparam logic [3:0] ERR_BAD_ESCAPE = 4'd10;
  localparam logic [3:0] ERR_DIGIT      = 4'd11;
  localparam logic [3:0] ERR_FLOAT      = 4'd12;
  localparam logic [3:0] ERR_RANGE      = 4'd13;

  localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [3:0]  ev;
    logic [7:0]  ch;
    logic        key;
    logic [63:0] num;
    logic [6:0]  nest;
    logic [3:0]  code;
    logic [30:0] line;
    logic [30:0] col;
  } res_t;

  // The results of one input beat: one or two of them.
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } pair_t;

  function automatic res_t mk_res(input logic [3:0] ev, input logic [7:0] ch,
                                  input logic key, input logic [63:0] num,
                                  input logic [6:0] nest, input logic [3:0] code,
                                  input logic [30:0] line, input logic [30:0] col);
    res_t r;
    r.ev = ev; r.ch = ch; r.key = key; r.num = num;
    r.nest = nest; r.code = code; r.line = line; r.col = col;
    return r;
  endfunction

endpackage
`default_nettype wire

### design/jst_front.sv
// Front end: grammar state machine, container stack and number/literal decoding.
`default_nettype none
module jst_front #(
  parameter int MAX_NEST = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire logic           command,
  input  wire logic [7:0]     byte_in,
  output jst_pkg::pair_t      pair,
  output logic                has_res
);
  import jst_pkg::*;

  localparam int NW = $clog2(MAX_NEST + 2);

  typedef enum logic [12:0] {
    M_VALUE     = 13'b0000000000001,
    M_ARR_FIRST = 13'b0000000000010,
    M_OBJ_FIRST = 13'b0000000000100,
    M_OBJ_KEY   = 13'b0000000001000,
    M_COLON     = 13'b0000000010000,
    M_AFTER     = 13'b0000000100000,
    M_STR       = 13'b0000001000000,
    M_STR_ESC   = 13'b0000010000000,
    M_KEY       = 13'b0000100000000,
    M_KEY_ESC   = 13'b0001000000000,
    M_NUM_SIGN  = 13'b0010000000000,
    M_NUM       = 13'b0100000000000,
    M_LIT       = 13'b1000000000000
  } mode_t;

  mode_t          mode, mode_next;
  logic [MAX_NEST:0] stk, stk_next;
  logic [NW-1:0]  nest, nest_next;
  logic [1:0]     litk, litk_next;
  logic [2:0]     liti, liti_next;
  logic [63:0]    mag, mag_next;
  logic           neg, neg_next;
  logic [30:0]    line, line_next, col, col_next;
  logic [30:0]    lsl, lsl_next, lsc, lsc_next;
  logic           failed, failed_next;

  res_t        res [2];
  logic [1:0]  cnt;

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: case (i) 3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                     default: c = 8'h00; endcase
      2'd1: case (i) 3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
                     3'd4: c = "e"; default: c = 8'h00; endcase
      2'd2: case (i) 3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                     default: c = 8'h00; endcase
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  always_comb begin
    logic        ws, dig, do_start, do_after, do_end_after, key, top_obj, fin_ok, hit;
    logic [30:0] pl, pc, ql, qc;
    logic [67:0] prod;
    logic [7:0]  ec;
    logic        ec_ok;
    logic [2:0]  llen;
    mode_next = mode; stk_next = stk; nest_next = nest; litk_next = litk;
    liti_next = liti; mag_next = mag; neg_next = neg; line_next = line;
    col_next = col; lsl_next = lsl; lsc_next = lsc; failed_next = failed;
    res[0] = '0; res[1] = '0; cnt = 2'd0;
    ws = (byte_in == 8'h20) || (byte_in == 8'h09) || (byte_in == 8'h0D) ||
         (byte_in == 8'h0A);
    dig = (byte_in >= "0") && (byte_in <= "9");
    do_start = 1'b0; do_after = 1'b0; do_end_after = 1'b0; key = 1'b0;
    top_obj = 1'b0; fin_ok = 1'b0; hit = 1'b0; prod = '0; ec = 8'h00; ec_ok = 1'b0;
    llen = 3'd4;
    pl = line; pc = col;
    if (byte_in == 8'h0A) begin
      ql = (line < POS_MAX) ? line + 31'd1 : line;
      qc = 31'd1;
    end else begin
      ql = line;
      qc = (col < POS_MAX) ? col + 31'd1 : col;
    end

    if (!failed && !command) begin
      line_next = ql; col_next = qc;
      case (mode)
        M_VALUE: do_start = !ws;
        M_ARR_FIRST: begin
          if (!ws) begin
            if (byte_in == "]") begin
              if (nest_next != '0) begin
                nest_next = nest_next - NW'(1); stk_next = stk_next >> 1;
              end
              res[cnt[0]] = mk_res(EV_ARR_END, 8'h00, 1'b0, '0, 7'(nest_next), 4'd0,
                                   31'd0, 31'd0);
              cnt = cnt + 2'd1;
              mode_next = M_AFTER;
            end else begin
              do_start = 1'b1;
            end
          end
        end
        M_OBJ_FIRST, M_OBJ_KEY: begin
          if (!ws) begin
            if (byte_in == "}" && mode == M_OBJ_FIRST) begin
              if (nest_next != '0) begin
                nest_next = nest_next - NW'(1); stk_next = stk_next >> 1;
              end
              res[cnt[0]] = mk_res(EV_OBJ_END, 8'h00, 1'b0, '0, 7'(nest_next), 4'd0,
                                   31'd0, 31'd0);
              cnt = cnt + 2'd1;
              mode_next = M_AFTER;
            end else if (byte_in == 8'h22) begin
              mode_next = M_KEY;
            end else begin
              failed_next = 1'b1;
              res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next), ERR_KEY,
                                   pl, pc);
              cnt = cnt + 2'd1;
            end
          end
        end
        M_COLON: begin
          if (!ws) begin
            if (byte_in == ":") begin
              mode_next = M_VALUE;
            end else begin
              failed_next = 1'b1;
              res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next), ERR_COLON,
                                   ql, qc);
              cnt = cnt + 2'd1;
            end
          end
        end
        M_AFTER: do_after = 1'b1;
        M_STR, M_KEY: begin
          key = (mode == M_KEY);
          if (byte_in == 8'h22) begin
            res[cnt[0]] = mk_res(EV_STR_END, 8'h00, key, '0, 7'(nest_next), 4'd0,
                                 31'd0, 31'd0);
            cnt = cnt + 2'd1;
            mode_next = key ? M_COLON : M_AFTER;
          end else if (byte_in < 8'h20) begin
            failed_next = 1'b1;
            res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next), ERR_CONTROL,
                                 ql, qc);
            cnt = cnt + 2'd1;
          end else if (byte_in == 8'h5C) begin
            mode_next = key ? M_KEY_ESC : M_STR_ESC;
          end else begin
            res[cnt[0]] = mk_res(EV_STR_BYTE, byte_in, key, '0, 7'(nest_next), 4'd0,
                                 31'd0, 31'd0);
            cnt = cnt + 2'd1;
          end
        end
        M_STR_ESC, M_KEY_ESC: begin
          key = (mode == M_KEY_ESC);
          ec_ok = 1'b1;
          case (byte_in)
            8'h22: ec = 8'h22;
            8'h5C: ec = 8'h5C;
            8'h2F: ec = 8'h2F;
            "b":   ec = 8'h08;
            "f":   ec = 8'h0C;
            "n":   ec = 8'h0A;
            "r":   ec = 8'h0D;
            "t":   ec = 8'h09;
            default: ec_ok = 1'b0;
          endcase
          if (ec_ok) begin
            res[cnt[0]] = mk_res(EV_STR_BYTE, ec, key, '0, 7'(nest_next), 4'd0,
                                 31'd0, 31'd0);
            cnt = cnt + 2'd1;
            mode_next = key ? M_KEY : M_STR;
          end else begin
            failed_next = 1'b1;
            res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next),
                                 (byte_in == "u") ? ERR_U_ESCAPE : ERR_BAD_ESCAPE,
                                 ql, qc);
            cnt = cnt + 2'd1;
          end
        end
        M_NUM_SIGN: begin
          if (dig) begin
            mag_next = 64'(byte_in - "0");
            mode_next = M_NUM;
          end else begin
            failed_next = 1'b1;
            res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next), ERR_DIGIT,
                                 pl, pc);
            cnt = cnt + 2'd1;
          end
        end
        M_NUM: begin
          if (dig) begin
            // Ten times the magnitude as two shifted copies, plus the digit.
            prod = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + 68'(byte_in - "0");
            mag_next = (prod[67:64] != 4'd0) ? {64{1'b1}} : prod[63:0];
          end else if (byte_in == "." || byte_in == "e" || byte_in == "E") begin
            failed_next = 1'b1;
            res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next), ERR_FLOAT,
                                 pl, pc);
            cnt = cnt + 2'd1;
          end else begin
            fin_ok = neg ? (mag <= 64'h8000_0000_0000_0000) : !mag[63];
            if (fin_ok) begin
              res[cnt[0]] = mk_res(EV_INTEGER, 8'h00, 1'b0, neg ? (64'd0 - mag) : mag,
                                   7'(nest_next), 4'd0, 31'd0, 31'd0);
              cnt = cnt + 2'd1;
              mode_next = M_AFTER;
              do_after = 1'b1;
            end else begin
              failed_next = 1'b1;
              res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next), ERR_RANGE,
                                   pl, pc);
              cnt = cnt + 2'd1;
            end
          end
        end
        M_LIT: begin
          llen = (litk == 2'd1) ? 3'd5 : 3'd4;
          hit = (litk != 2'd3) && (liti < llen) && (byte_in == lit_char(litk, liti));
          if (hit) begin
            if (liti + 3'd1 == llen) begin
              res[cnt[0]] = mk_res(EV_TRUE + 4'(litk), 8'h00, 1'b0, '0, 7'(nest_next),
                                   4'd0, 31'd0, 31'd0);
              cnt = cnt + 2'd1;
              litk_next = 2'd0; liti_next = 3'd0;
              mode_next = M_AFTER;
            end else begin
              liti_next = liti + 3'd1;
            end
          end else begin
            failed_next = 1'b1;
            res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next), ERR_VALUE,
                                 lsl, lsc);
            cnt = cnt + 2'd1;
          end
        end
        default: begin
          failed_next = 1'b1;
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next), ERR_VALUE,
                               pl, pc);
          cnt = cnt + 2'd1;
        end
      endcase

      if (do_start) begin
        if (nest_next > NW'(MAX_NEST)) begin
          failed_next = 1'b1;
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next), ERR_TOO_DEEP,
                               pl, pc);
          cnt = cnt + 2'd1;
        end else if (byte_in == "{" || byte_in == "[") begin
          stk_next = {stk_next[MAX_NEST-1:0], (byte_in == "{")};
          nest_next = nest_next + NW'(1);
          res[cnt[0]] = mk_res((byte_in == "{") ? EV_OBJ_BEGIN : EV_ARR_BEGIN, 8'h00,
                               1'b0, '0, 7'(nest_next), 4'd0, 31'd0, 31'd0);
          cnt = cnt + 2'd1;
          mode_next = (byte_in == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
        end else if (byte_in == 8'h22) begin
          mode_next = M_STR;
        end else if (byte_in == "t" || byte_in == "f" || byte_in == "n") begin
          litk_next = (byte_in == "t") ? 2'd0 : (byte_in == "f") ? 2'd1 : 2'd2;
          liti_next = 3'd1;
          lsl_next = pl; lsc_next = pc;
          mode_next = M_LIT;
        end else if (byte_in == "-") begin
          neg_next = 1'b1; mag_next = '0;
          mode_next = M_NUM_SIGN;
        end else if (dig) begin
          neg_next = 1'b0; mag_next = 64'(byte_in - "0");
          mode_next = M_NUM;
        end else begin
          failed_next = 1'b1;
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next), ERR_VALUE,
                               pl, pc);
          cnt = cnt + 2'd1;
        end
      end

      if (do_after && !ws) begin
        top_obj = (nest_next != '0) && stk_next[0];
        if (nest_next == '0) begin
          failed_next = 1'b1;
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next), ERR_TRAILING,
                               pl, pc);
          cnt = cnt + 2'd1;
        end else if ((top_obj && byte_in == "}") || (!top_obj && byte_in == "]")) begin
          nest_next = nest_next - NW'(1); stk_next = stk_next >> 1;
          res[cnt[0]] = mk_res(top_obj ? EV_OBJ_END : EV_ARR_END, 8'h00, 1'b0, '0,
                               7'(nest_next), 4'd0, 31'd0, 31'd0);
          cnt = cnt + 2'd1;
        end else if (byte_in == ",") begin
          mode_next = top_obj ? M_OBJ_KEY : M_VALUE;
        end else begin
          failed_next = 1'b1;
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest_next),
                               top_obj ? ERR_OBJ_SEP : ERR_ARR_SEP, ql, qc);
          cnt = cnt + 2'd1;
        end
      end
    end else if (!failed && command) begin
      case (mode)
        M_VALUE, M_ARR_FIRST: begin
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest),
                               (nest > NW'(MAX_NEST)) ? ERR_TOO_DEEP : ERR_VALUE,
                               line, col);
          cnt = cnt + 2'd1;
        end
        M_OBJ_FIRST, M_OBJ_KEY: begin
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest), ERR_KEY, line, col);
          cnt = cnt + 2'd1;
        end
        M_COLON: begin
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest), ERR_COLON, line, col);
          cnt = cnt + 2'd1;
        end
        M_AFTER: do_end_after = 1'b1;
        M_STR, M_KEY: begin
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest), ERR_UNTERM, line, col);
          cnt = cnt + 2'd1;
        end
        M_STR_ESC, M_KEY_ESC: begin
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest), ERR_BAD_ESCAPE,
                               line, col);
          cnt = cnt + 2'd1;
        end
        M_NUM_SIGN: begin
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest), ERR_DIGIT, line, col);
          cnt = cnt + 2'd1;
        end
        M_NUM: begin
          fin_ok = neg ? (mag <= 64'h8000_0000_0000_0000) : !mag[63];
          if (fin_ok) begin
            res[cnt[0]] = mk_res(EV_INTEGER, 8'h00, 1'b0, neg ? (64'd0 - mag) : mag,
                                 7'(nest), 4'd0, 31'd0, 31'd0);
            cnt = cnt + 2'd1;
            do_end_after = 1'b1;
          end else begin
            res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest), ERR_RANGE,
                                 line, col);
            cnt = cnt + 2'd1;
          end
        end
        M_LIT: begin
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest), ERR_VALUE, lsl, lsc);
          cnt = cnt + 2'd1;
        end
        default: begin
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest), ERR_VALUE, line, col);
          cnt = cnt + 2'd1;
        end
      endcase
      if (do_end_after) begin
        if (nest == '0) begin
          res[cnt[0]] = mk_res(EV_DONE, 8'h00, 1'b0, '0, 7'(nest), 4'd0, 31'd0, 31'd0);
        end else begin
          res[cnt[0]] = mk_res(EV_ERROR, 8'h00, 1'b0, '0, 7'(nest),
                               stk[0] ? ERR_OBJ_SEP : ERR_ARR_SEP, line, col);
        end
        cnt = cnt + 2'd1;
      end
    end

    if (command) begin
      mode_next = M_VALUE; nest_next = '0; litk_next = 2'd0; liti_next = 3'd0;
      mag_next = '0; neg_next = 1'b0; line_next = 31'd1; col_next = 31'd1;
      lsl_next = 31'd0; lsc_next = 31'd0; failed_next = 1'b0;
    end
  end

  assign pair.r0  = res[0];
  assign pair.r1  = res[1];
  assign pair.two = cnt[1];
  assign has_res  = (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_VALUE; nest <= '0; litk <= 2'd0; liti <= 3'd0; mag <= '0; neg <= 1'b0;
      line <= 31'd1; col <= 31'd1; lsl <= 31'd0; lsc <= 31'd0; failed <= 1'b0;
    end else if (take) begin
      mode <= mode_next; nest <= nest_next; litk <= litk_next; liti <= liti_next;
      mag <= mag_next; neg <= neg_next; line <= line_next; col <= col_next;
      lsl <= lsl_next; lsc <= lsc_next; failed <= failed_next;
    end
  end

  // Container kinds are held as a shift line; the top of stack is always bit 0.
  always_ff @(posedge clk) begin
    if (take) begin
      stk <= stk_next;
    end
  end

endmodule
`default_nettype wire

### design/jst_queue.sv
// Short queue of result pairs between the front end and the output stage.
`default_nettype none
module jst_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  jst_pkg::pair_t      wr_data,
  input  wire logic           pop,
  output jst_pkg::pair_t      rd_data,
  output logic                not_empty,
  output logic                full
);
  import jst_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  pair_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   fill;

  assign rd_data   = slots[rptr];
  assign not_empty = (fill != '0);
  assign full      = (fill == (PW+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; fill <= '0;
    end else begin
      if (push) wptr <= wptr + PW'(1);
      if (pop) rptr <= rptr + PW'(1);
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### design/jst_back.sv
// Output stage: unpacks each result pair into one or two output beats.
`default_nettype none
module jst_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  jst_pkg::pair_t      q_data,
  input  wire logic           q_not_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output jst_pkg::res_t       cur,
  output logic                cur_last
);
  import jst_pkg::*;

  pair_t hold;
  logic  idx, busy, load;

  assign cur_last  = idx || !hold.two;
  assign cur       = idx ? hold.r1 : hold.r0;
  assign out_valid = busy;
  assign load      = !busy || (out_ready && cur_last);
  assign q_pop     = load && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; idx <= 1'b0;
    end else if (load) begin
      busy <= q_not_empty; idx <= 1'b0;
    end else if (out_ready) begin
      idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold <= q_data;
    end
  end

endmodule
`default_nettype wire

### design/json_stream_tokenizer.sv
// Top level of the validating JSON stream tokenizer.
`default_nettype none
// The tokenizer takes one beat per clock: either a text byte (command 0) or
// an end-of-text command (command 1). The front end decodes combinationally,
// so a byte can follow in the very next cycle, and it produces zero, one or two
// result beats. Those results travel as one pair through a four-entry queue
// to the output stage, which shows them one per cycle while out_ready is
// high. The sustained rate is therefore one input beat per clock while beats
// give at most one result each; a beat that gives two results (a number
// ended by a closing bracket, or a final integer followed by done) puts out
// two beats, and the queue absorbs short bursts of these. Input ready falls
// only when the queue is full. Nesting is limited to MAX_NEST+1 levels; the
// container stack is a shift line of MAX_NEST+1 bits with its top at a fixed
// place, so no clearing pass is needed after reset. After the first error all
// bytes are dropped until an end-of-text beat, which re-arms the parser.
module json_stream_tokenizer #(
  parameter int MAX_NEST = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [7:0]  byte_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       event_res,
  output logic [7:0]       char_out,
  output logic             is_key,
  output logic signed [63:0] number,
  output logic [6:0]       nest_level,
  output logic [3:0]       error_code,
  output logic [30:0]      err_line,
  output logic [30:0]      err_column,
  output logic             last
);
  import jst_pkg::*;

  pair_t f_pair, q_pair;
  res_t  cur;
  logic  f_has, take, q_full, q_ne, q_pop;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  jst_front #(.MAX_NEST(MAX_NEST)) u_front (
    .clk(clk), .rst(rst), .take(take), .command(command), .byte_in(byte_in),
    .pair(f_pair), .has_res(f_has)
  );

  jst_queue u_queue (
    .clk(clk), .rst(rst), .push(take && f_has), .wr_data(f_pair), .pop(q_pop),
    .rd_data(q_pair), .not_empty(q_ne), .full(q_full)
  );

  jst_back u_back (
    .clk(clk), .rst(rst), .q_data(q_pair), .q_not_empty(q_ne), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .cur(cur), .cur_last(last)
  );

  assign event_res  = cur.ev;
  assign char_out   = cur.ch;
  assign is_key     = cur.key;
  assign number     = cur.num;
  assign nest_level = cur.nest;
  assign error_code = cur.code;
  assign err_line   = cur.line;
  assign err_column = cur.col;

endmodule
`default_nettype wire

### design/jst_checker.sv
// Port-level checks for the JSON stream tokenizer and their binding.
`default_nettype none
module jst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  event_res,
  input wire logic [3:0]  error_code,
  input wire logic [30:0] err_line,
  input wire logic [30:0] err_column,
  input wire logic [6:0]  nest_level,
  input wire logic        last
);
  import jst_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output beat dropped");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_res <= EV_ERROR) else $error("unknown event");

  a_err_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_ERROR |-> err_line != 0 && err_column != 0 && last)
    else $error("error beat without location");

  a_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_ERROR |-> error_code == 0 && err_line == 0)
    else $error("error fields on a non-error beat");

  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_DONE |-> nest_level == 0 && last)
    else $error("done with open containers");

endmodule

bind json_stream_tokenizer jst_checker u_jst_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .event_res(event_res), .error_code(error_code), .err_line(err_line),
  .err_column(err_column), .nest_level(nest_level), .last(last)
);
`default_nettype wire
